>>> hw/rtl/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg: shared types and constants of the quadrature position counter
// Field widths, register indexes, state and configuration records, and the
// x4 transition table of the two encoder lines.
// ----------------------------------------------------------------------------
`default_nettype none

package qpc_pkg;

	localparam int PosW     = 16;	// position in whole detents, signed
	localparam int QuarterW = 18;	// quarter-step counter, signed
	localparam int BoundW   = 8;	// bound registers, unsigned
	localparam int LinesW   = 2;	// {line_b, line_a}
	localparam int InDataW  = 24;	// line_a, line_b, new_position, padded
	localparam int OutDataW = 24;	// position, moved, padded
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 8;

	localparam logic [LinesW-1:0]       LinesReset  = 2'b11;
	localparam logic [QuarterW-1:0]     QuarterMax  = 18'h1FFFF;
	localparam logic [QuarterW-1:0]     QuarterMin  = 18'h20000;
	localparam logic [BoundW-1:0]       MinReset    = 8'd0;
	localparam logic [BoundW-1:0]       MaxReset    = 8'd255;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_POSITION = 2'd0,
		REG_MAX_POSITION = 2'd1,
		REG_WRAP_ENABLE  = 2'd2
	} cfg_reg_t;

	// item kinds carried on tuser
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef struct packed {
		logic [BoundW-1:0] min_position;
		logic [BoundW-1:0] max_position;
		logic              wrap_enable;
	} cfg_t;

	typedef struct packed {
		logic [LinesW-1:0]   last_lines;
		logic [QuarterW-1:0] quarter_count;
	} state_t;

	// x4 transition table, indexed by {old pair, new pair}; -1, 0 or +1
	function automatic logic [1:0] step_delta(input logic [3:0] idx);
		logic [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = 2'b11;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'b01;
			default: d = 2'b00;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/quadrature_position_counter.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter: x4 quadrature decoder with bounded position
// Input register, single-pass update logic and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one item per transfer. tuser is the kind (0 sample the
//   encoder lines, 1 load new_position); tdata carries line_a, line_b and
//   new_position. Master stream m_*: one result per item with the position
//   in whole detents and the moved flag.
//   Configuration channel cfg_*: writes min_position, max_position and
//   wrap_enable by index; index 3 is ignored. Write only while idle.
// Timing:
//   An input transfer is held in the input register, then its result in the
//   result register before it appears on m_*. The counter update is one
//   short pass of logic, so one item per cycle is sustained while m_tready is high.
// Stall:
//   When m_tready is low the result holds, the input register still takes
//   one item, and s_tready drops only once both stages are full.
// Reset:
//   arst_n clears both stages, sets the stored line pair to both high, the
//   quarter count to zero and the bounds to 0 and 255 with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_position_counter (
	input  wire                              clk,
	input  wire                              arst_n,
	// input stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [qpc_pkg::InDataW-1:0]       s_tdata,	// line_a, line_b, new_position[15:0], pad
	input  wire                              s_tuser,	// kind
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [qpc_pkg::OutDataW-1:0]     m_tdata,	// position[15:0], moved, pad
	// configuration writes
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [qpc_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire [qpc_pkg::CfgDataW-1:0]      cfg_data
);
	import qpc_pkg::*;

	logic                 valid_s1;
	logic                 kind_s1;
	logic [LinesW-1:0]    lines_s1;
	logic [PosW-1:0]      new_pos_s1;
	logic                 valid_s2;
	logic [PosW-1:0]      position_s2;
	logic                 moved_s2;
	logic                 advance;
	cfg_t                 cfg_q;
	state_t               state_q;
	state_t               next_state;
	logic [PosW-1:0]      position;
	logic                 moved;

	// move stage 1 on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// capture input transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1    <= s_tuser;
			lines_s1   <= s_tdata[LinesW-1:0];
			new_pos_s1 <= s_tdata[LinesW+PosW-1:LinesW];
		end
	end

	// write configuration registers by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_position <= MinReset;
			cfg_q.max_position <= MaxReset;
			cfg_q.wrap_enable  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_POSITION: cfg_q.min_position <= cfg_data;
				REG_MAX_POSITION: cfg_q.max_position <= cfg_data;
				REG_WRAP_ENABLE:  cfg_q.wrap_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	qpc_step u_step (
		.state        (state_q),
		.cfg          (cfg_q),
		.kind         (kind_s1),
		.lines        (lines_s1),
		.new_position (new_pos_s1),
		.next_state   (next_state),
		.position     (position),
		.moved        (moved)
	);

	// advance the counter state with each item leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_lines    <= LinesReset;
			state_q.quarter_count <= '0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			position_s2 <= position;
			moved_s2    <= moved;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW-PosW-1){1'b0}}, moved_s2, position_s2};

	// state holds while no item moves through the update logic
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q.quarter_count) && $stable(state_q.last_lines))
		else $error("counter state changed without an item");

	// a load keeps the two low quarter bits
	a_load_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_LOAD
		|=> state_q.quarter_count[1:0] == $past(state_q.quarter_count[1:0]))
		else $error("load disturbed the quarter bits");

	// a sample leaves the position inside ordered bounds
	a_sample_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_SAMPLE && cfg_q.min_position <= cfg_q.max_position
		|=> ($signed(position_s2) >= $signed({8'd0, $past(cfg_q.min_position)}))
		&& ($signed(position_s2) <= $signed({8'd0, $past(cfg_q.max_position)})))
		else $error("sampled position outside bounds");

	// a load never reports movement
	a_load_not_moved: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == KIND_LOAD |=> !moved_s2)
		else $error("load reported movement");

endmodule

`default_nettype wire

>>> hw/rtl/qpc_step.sv
// ----------------------------------------------------------------------------
// qpc_step: next-state logic for one item
// Applies a line sample (table step, saturation, bound clamp or wrap) or a
// position load to the counter state and forms the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module qpc_step (
	input  wire qpc_pkg::state_t                 state,
	input  wire qpc_pkg::cfg_t                   cfg,
	input  wire                                  kind,
	input  wire [qpc_pkg::LinesW-1:0]            lines,
	input  wire [qpc_pkg::PosW-1:0]              new_position,
	output qpc_pkg::state_t                      next_state,
	output logic [qpc_pkg::PosW-1:0]             position,
	output logic                                 moved
);
	import qpc_pkg::*;

	logic                  changed;
	logic [1:0]            delta;
	logic [QuarterW:0]     sum;
	logic [QuarterW-1:0]   stepped;
	logic [PosW-1:0]       pos;
	logic [PosW-1:0]       min_ext;
	logic [PosW-1:0]       max_ext;
	logic [BoundW-1:0]     bound;
	logic                  below;
	logic                  above;

	// step the quarter count with saturation at the counter limits
	assign changed = (lines != state.last_lines);
	assign delta   = step_delta({state.last_lines, lines});
	assign sum     = {state.quarter_count[QuarterW-1], state.quarter_count}
		+ {{(QuarterW-1){delta[1]}}, delta};

	always_comb begin
		if (!changed) begin
			stepped = state.quarter_count;
		end else if (sum[QuarterW] != sum[QuarterW-1]) begin
			stepped = sum[QuarterW] ? QuarterMin : QuarterMax;
		end else begin
			stepped = sum[QuarterW-1:0];
		end
	end

	// check the stepped position against the bounds, lower bound first
	assign pos     = stepped[QuarterW-1:2];
	assign min_ext = {{(PosW-BoundW){1'b0}}, cfg.min_position};
	assign max_ext = {{(PosW-BoundW){1'b0}}, cfg.max_position};
	assign below   = $signed(pos) < $signed(min_ext);
	assign above   = $signed(pos) > $signed(max_ext);

	always_comb begin
		if (below) begin
			bound = cfg.wrap_enable ? cfg.max_position : cfg.min_position;
		end else begin
			bound = cfg.wrap_enable ? cfg.min_position : cfg.max_position;
		end
	end

	// pick the new state; loads keep the two low quarter bits
	always_comb begin
		next_state = state;
		moved      = 1'b0;
		if (kind == KIND_LOAD) begin
			next_state.quarter_count = {new_position, state.quarter_count[1:0]};
		end else begin
			moved                 = changed;
			next_state.last_lines = lines;
			if (below || above) begin
				next_state.quarter_count = {{(PosW-BoundW){1'b0}}, bound, stepped[1:0]};
			end else begin
				next_state.quarter_count = stepped;
			end
		end
	end

	assign position = next_state.quarter_count[QuarterW-1:2];

endmodule

`default_nettype wire
